// ===== rtl/core/p2c_pkg.sv =====
`timescale 1ns / 1ps

package p2c_pkg;

	// Quarter-wave sine arithmetic is unsigned Q30 carried in 31 bits so that 1.0 fits.
	localparam int FRAC_W = 30;
	localparam int TRIG_W = FRAC_W + 1;
	localparam int PROD_W = 2 * TRIG_W;

	localparam logic [TRIG_W-1:0] Q30_ONE = TRIG_W'(1) << FRAC_W;

	// Odd polynomial coefficients of sin(pi/2 * z), Q30.
	localparam logic [TRIG_W-1:0] C1 = 31'd1686629713;
	localparam logic [TRIG_W-1:0] C3 = 31'd693598670;
	localparam logic [TRIG_W-1:0] C5 = 31'd85569306;
	localparam logic [TRIG_W-1:0] C7 = 31'd5026994;
	localparam logic [TRIG_W-1:0] C9 = 31'd172271;

	// Quadrant codes taken from the top two phase bits.
	typedef logic [1:0] quad_t;
	localparam quad_t QUAD_FIRST  = 2'd0;
	localparam quad_t QUAD_SECOND = 2'd1;
	localparam quad_t QUAD_THIRD  = 2'd2;
	localparam quad_t QUAD_FOURTH = 2'd3;

	typedef logic [TRIG_W-1:0] trig_t;

endpackage

// ===== rtl/core/p2c_in_if.sv =====
`timescale 1ns / 1ps

interface p2c_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int PHASE_WIDTH  = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] amplitude;
	logic        [PHASE_WIDTH-1:0]  phase;

	modport source (output valid, output amplitude, output phase, input ready);
	modport sink (input valid, input amplitude, input phase, output ready);
endinterface

// ===== rtl/core/p2c_out_if.sv =====
`timescale 1ns / 1ps

interface p2c_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] real_part;
	logic signed [SAMPLE_WIDTH-1:0] imag_part;

	modport source (output valid, output real_part, output imag_part, input ready);
	modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

// ===== rtl/core/polar_to_cartesian_core.sv =====
`timescale 1ns / 1ps

// Polar to rectangular conversion.
// Requests arrive on the polar channel (signed Q1.15 amplitude, unsigned phase where a
// full turn is 2^PHASE_WIDTH) and leave on the rect channel as real_part = A*cos(phase)
// and imag_part = A*sin(phase), signed Q1.15, saturated to plus or minus full scale
// less one. Both channels use a valid/ready handshake.
// One request is taken every cycle unless a held result stalls the pipeline. There are
// nine register stages, namely the input split, six quarter-sine stages (phase square,
// four polynomial steps, the scaling by z), the amplitude product, then rounding and
// saturation into the output register.
// cfg_we writes cfg_wdata into the enable register; while it is clear, accepted
// requests are dropped and give no result.
// Reset empties the pipeline and sets enable. When the receiver holds rect.ready low
// with a result waiting, the whole pipeline freezes, empty stages included, and
// polar.ready drops in the same cycle; nothing is lost or repeated.
module polar_to_cartesian_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int PHASE_WIDTH  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	p2c_in_if.sink     polar,
	p2c_out_if.source  rect
);
	import p2c_pkg::*;

	localparam int QS_LAT  = 6;
	localparam int MUL_W   = SAMPLE_WIDTH + TRIG_W;
	localparam int RND_W   = MUL_W + 1;
	localparam int MAG_W   = RND_W - FRAC_W;
	localparam logic [MAG_W-1:0] MAG_LIMIT = (MAG_W'(1) << (SAMPLE_WIDTH - 1)) - MAG_W'(1);
	localparam logic [RND_W-1:0] RND_HALF  = RND_W'(1) << (FRAC_W - 1);

	typedef struct packed {
		quad_t                   quad;
		logic                    amp_neg;
		logic [SAMPLE_WIDTH-1:0] amp_mag;
	} meta_t;

	logic advance;
	logic enable_q;

	logic [FRAC_W-1:0] z_frac;
	logic [SAMPLE_WIDTH-1:0] amp_raw;

	logic  valid_s1;
	meta_t meta_s1;
	trig_t zf_s1, zb_s1;

	logic  [QS_LAT-1:0] vld_dly_q;
	meta_t [QS_LAT-1:0] meta_dly_q;

	trig_t sf_s7, sb_s7;
	trig_t cos_m, sin_m;
	logic  cos_n, sin_n;

	logic             valid_s8;
	logic [MUL_W-1:0] re_prod_s8, im_prod_s8;
	logic             re_neg_s8, im_neg_s8;

	logic [RND_W-1:0] re_rnd, im_rnd;
	logic [MAG_W-1:0] re_mag, im_mag;
	logic [SAMPLE_WIDTH-1:0] re_sat, im_sat;

	logic                           valid_s9;
	logic signed [SAMPLE_WIDTH-1:0] real_s9, imag_s9;

	// The pipeline moves as a whole unless a finished result is being held.
	assign advance     = !valid_s9 || rect.ready;
	assign polar.ready = advance;

	// Enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	// Stage 1: quadrant, angle within the quadrant and its complement, amplitude magnitude.
	assign z_frac  = FRAC_W'(polar.phase[PHASE_WIDTH-3:0]) << (32 - PHASE_WIDTH);
	assign amp_raw = polar.amplitude;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= polar.valid && enable_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1.quad    <= polar.phase[PHASE_WIDTH-1:PHASE_WIDTH-2];
			meta_s1.amp_neg <= amp_raw[SAMPLE_WIDTH-1];
			meta_s1.amp_mag <= amp_raw[SAMPLE_WIDTH-1] ? (~amp_raw + SAMPLE_WIDTH'(1)) : amp_raw;
			zf_s1           <= {1'b0, z_frac};
			zb_s1           <= Q30_ONE - {1'b0, z_frac};
		end
	end

	// Stages 2 to 7: both quarter sines in parallel.
	p2c_qsine u_qsine_fwd (
		.clk     (clk),
		.advance (advance),
		.z_in    (zf_s1),
		.sine    (sf_s7)
	);

	p2c_qsine u_qsine_bwd (
		.clk     (clk),
		.advance (advance),
		.z_in    (zb_s1),
		.sine    (sb_s7)
	);

	// Valid bits and sample side data travel alongside the sine pipelines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
		end else if (advance) begin
			vld_dly_q <= {vld_dly_q[QS_LAT-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_dly_q <= {meta_dly_q[QS_LAT-2:0], meta_s1};
		end
	end

	// Quadrant folding of the two quarter sines into cosine and sine with signs.
	always_comb begin
		case (meta_dly_q[QS_LAT-1].quad)
			QUAD_FIRST: begin
				sin_m = sf_s7; sin_n = 1'b0; cos_m = sb_s7; cos_n = 1'b0;
			end
			QUAD_SECOND: begin
				sin_m = sb_s7; sin_n = 1'b0; cos_m = sf_s7; cos_n = 1'b1;
			end
			QUAD_THIRD: begin
				sin_m = sf_s7; sin_n = 1'b1; cos_m = sb_s7; cos_n = 1'b1;
			end
			default: begin
				sin_m = sb_s7; sin_n = 1'b1; cos_m = sf_s7; cos_n = 1'b0;
			end
		endcase
	end

	// Stage 8: amplitude times trig magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (advance) begin
			valid_s8 <= vld_dly_q[QS_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_prod_s8 <= MUL_W'(meta_dly_q[QS_LAT-1].amp_mag) * MUL_W'(cos_m);
			im_prod_s8 <= MUL_W'(meta_dly_q[QS_LAT-1].amp_mag) * MUL_W'(sin_m);
			re_neg_s8  <= meta_dly_q[QS_LAT-1].amp_neg ^ cos_n;
			im_neg_s8  <= meta_dly_q[QS_LAT-1].amp_neg ^ sin_n;
		end
	end

	// Round half away from zero on the magnitude, saturate, then apply the sign.
	assign re_rnd = RND_W'(re_prod_s8) + RND_HALF;
	assign im_rnd = RND_W'(im_prod_s8) + RND_HALF;
	assign re_mag = re_rnd[RND_W-1:FRAC_W];
	assign im_mag = im_rnd[RND_W-1:FRAC_W];
	assign re_sat = (re_mag > MAG_LIMIT) ? SAMPLE_WIDTH'(MAG_LIMIT) : SAMPLE_WIDTH'(re_mag);
	assign im_sat = (im_mag > MAG_LIMIT) ? SAMPLE_WIDTH'(MAG_LIMIT) : SAMPLE_WIDTH'(im_mag);

	// Stage 9: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (advance) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			real_s9 <= re_neg_s8 ? (~re_sat + SAMPLE_WIDTH'(1)) : re_sat;
			imag_s9 <= im_neg_s8 ? (~im_sat + SAMPLE_WIDTH'(1)) : im_sat;
		end
	end

	assign rect.valid     = valid_s9;
	assign rect.real_part = real_s9;
	assign rect.imag_part = imag_s9;

`ifndef SYNTH
	// A request taken while disabled must not enter the pipeline.
	a_disabled_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(polar.valid && polar.ready && !enable_q) |=> !valid_s1)
		else $error("request entered the pipeline while disabled");

	// A held result freezes the pipeline, so no request may be taken.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rect.valid && !rect.ready) |-> !polar.ready)
		else $error("request taken while a result is held");

	// Saturation keeps both outputs off the most negative code.
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		rect.valid |-> (real_s9 != {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}) &&
			(imag_s9 != {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
		else $error("output reached the most negative code");

	// A held result stays unchanged until it is taken.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rect.valid && !rect.ready) |=> rect.valid && $stable(real_s9) && $stable(imag_s9))
		else $error("held result changed");
`endif

endmodule

// ===== rtl/core/p2c_qsine.sv =====
`timescale 1ns / 1ps

// Six-stage pipelined quarter-wave sine, sin(pi/2 * z) in Q30, one multiplier per stage.
module p2c_qsine (
	input  logic           clk,
	input  logic           advance,
	input  p2c_pkg::trig_t z_in,
	output p2c_pkg::trig_t sine
);
	import p2c_pkg::*;

	logic [PROD_W-1:0] sq_prod;
	logic [PROD_W-1:0] h7_prod;
	logic [PROD_W-1:0] h5_prod;
	logic [PROD_W-1:0] h3_prod;
	logic [PROD_W-1:0] h1_prod;
	logic [PROD_W-1:0] fin_prod;
	logic [PROD_W-FRAC_W-1:0] fin_shift;

	trig_t z_s1, z_s2, z_s3, z_s4, z_s5;
	trig_t z2_s1, z2_s2, z2_s3, z2_s4;
	trig_t p_s2, p_s3, p_s4, p_s5;
	trig_t sine_s6;

	// One product per stage: square, four Horner steps, then the final scaling by z.
	assign sq_prod   = PROD_W'(z_in) * PROD_W'(z_in);
	assign h7_prod   = PROD_W'(C9) * PROD_W'(z2_s1);
	assign h5_prod   = PROD_W'(p_s2) * PROD_W'(z2_s2);
	assign h3_prod   = PROD_W'(p_s3) * PROD_W'(z2_s3);
	assign h1_prod   = PROD_W'(p_s4) * PROD_W'(z2_s4);
	assign fin_prod  = PROD_W'(p_s5) * PROD_W'(z_s5);
	assign fin_shift = fin_prod[PROD_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (advance) begin
			z_s1    <= z_in;
			z2_s1   <= trig_t'(sq_prod >> FRAC_W);
			z_s2    <= z_s1;
			z2_s2   <= z2_s1;
			p_s2    <= C7 - trig_t'(h7_prod >> FRAC_W);
			z_s3    <= z_s2;
			z2_s3   <= z2_s2;
			p_s3    <= C5 - trig_t'(h5_prod >> FRAC_W);
			z_s4    <= z_s3;
			z2_s4   <= z2_s3;
			p_s4    <= C3 - trig_t'(h3_prod >> FRAC_W);
			z_s5    <= z_s4;
			p_s5    <= C1 - trig_t'(h1_prod >> FRAC_W);
			// The polynomial may overshoot 1.0 slightly near the top of the quadrant.
			if (fin_shift > (PROD_W-FRAC_W)'(Q30_ONE)) begin
				sine_s6 <= Q30_ONE;
			end else begin
				sine_s6 <= trig_t'(fin_shift);
			end
		end
	end

	assign sine = sine_s6;

endmodule
